// ----- rtl/core/tscg_pkg.sv -----
// Shared types and constants for the tempo-synced clock generator.
// Used by the front end, the executor and the top level; no dependencies.
package tscg_pkg;

    // Fixed field widths.
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned BPM_W   = 17;
    localparam int unsigned DIV_W   = 5;
    localparam int unsigned BEAT_W  = 22;
    localparam int unsigned RATE_W  = 18;

    // Minimum tempo in Q.8 bpm (one beat per minute).
    localparam logic [BPM_W-1:0] TEMPO_MIN   = 17'd256;
    localparam logic [BPM_W-1:0] TEMPO_RESET = 17'd30720;
    localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

    // Divider sizing: the widest dividend is rate*60*beat (46 bits).
    localparam int unsigned DIV_NUM_W = 46;
    localparam int unsigned DIV_CNT_W = 6;
    // rate*120*256 fits in 33 bits.
    localparam int unsigned PER_NUM_W = 33;
    // rate*60*beat/(tempo*256) fits in 30 bits since tempo is at least 256.
    localparam int unsigned TGT_W     = 30;
    // tempo*256 divisor width.
    localparam int unsigned TDEN_W    = 25;
    // tempo*divisions divisor width.
    localparam int unsigned PDEN_W    = 22;

    // Classified item codes.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_BLOCK = 2'd1;
    localparam logic [1:0] CMD_HOST  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Input kind codes.
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BLOCK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HOST  = 2'd2;

    // One classified item as it sits in the queue.
    typedef struct packed {
        logic [1:0]        op;
        logic [BPM_W-1:0]  bpm;       // already clamped to TEMPO_MIN
        logic [DIV_W-1:0]  div;       // zero already replaced by one
        logic              sync;
        logic              has_bpm;
        logic              has_beat;
        logic [BEAT_W-1:0] beat;
    } t_cmd;

    // Clamp a tempo to one bpm at least.
    function automatic logic [BPM_W-1:0] clamp_tempo(input logic [BPM_W-1:0] t);
        return (t < TEMPO_MIN) ? TEMPO_MIN : t;
    endfunction

endpackage

// ----- rtl/core/tscg_front.sv -----
// Front end: takes input transfers, classifies them and queues them.
// Depends on tscg_pkg.
module tscg_front
    import tscg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [BPM_W-1:0]  i_control_bpm,
    input  logic [DIV_W-1:0]  i_divisions_in,
    input  logic              i_sync_on,
    input  logic              i_has_host_bpm,
    input  logic [BPM_W-1:0]  i_host_bpm,
    input  logic              i_has_beat,
    input  logic [BEAT_W-1:0] i_host_beat,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output t_cmd              o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    // Classify the incoming item and normalize its fields.
    always_comb begin
        w_cmd          = '0;
        w_cmd.div      = (i_divisions_in == '0) ? DIV_W'(1) : i_divisions_in;
        w_cmd.sync     = i_sync_on;
        w_cmd.has_bpm  = i_has_host_bpm;
        w_cmd.has_beat = i_has_beat;
        w_cmd.beat     = i_host_beat;
        unique case (i_kind)
            KIND_TICK: begin
                w_cmd.op  = CMD_TICK;
                w_cmd.bpm = TEMPO_MIN;
            end
            KIND_BLOCK: begin
                w_cmd.op  = CMD_BLOCK;
                w_cmd.bpm = clamp_tempo(i_control_bpm);
            end
            KIND_HOST: begin
                w_cmd.op  = CMD_HOST;
                w_cmd.bpm = clamp_tempo(i_host_bpm);
            end
            default: begin
                w_cmd.op  = CMD_NONE;
                w_cmd.bpm = TEMPO_MIN;
            end
        endcase
    end

    // Unused kinds are taken but never queued.
    assign o_in_ready  = (r_count != 2'd2);
    assign w_push      = i_in_valid && o_in_ready && (w_cmd.op != CMD_NONE);
    assign o_cmd_valid = (r_count != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_mem[r_rd_ptr];

    // Two-entry queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/core/tscg_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Dividend arrives left-aligned; i_steps gives its significant width. Uses tscg_pkg.
module tscg_div
    import tscg_pkg::*;
#(
    parameter int unsigned NUM_W = 46,
    parameter int unsigned DEN_W = 25
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [NUM_W-1:0]     i_num,
    input  logic [DEN_W-1:0]     i_den,
    input  logic [DIV_CNT_W-1:0] i_steps,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [NUM_W-1:0]     o_quot,
    output logic [DEN_W-1:0]     o_rem
);

    logic [NUM_W-1:0]     r_q;
    logic [DEN_W-1:0]     r_r;
    logic [DEN_W-1:0]     r_d;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DEN_W:0]       w_rem_sh;
    logic                 w_ge;
    logic [DEN_W:0]       w_diff;

    // One shift-compare-subtract step.
    assign w_rem_sh = {r_r, r_q[NUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_d});
    assign w_diff   = w_rem_sh - {1'b0, r_d};

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_r <= '0;
            r_d <= i_den;
        end else if (r_busy) begin
            r_q <= {r_q[NUM_W-2:0], w_ge};
            r_r <= w_ge ? w_diff[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
        end
    end

    // Step counter and status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= i_steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

// ----- rtl/core/tscg_exec.sv -----
// Back end: holds the clock state, runs ticks, host updates and block starts.
// Depends on tscg_pkg and tscg_div.
module tscg_exec
    import tscg_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  t_cmd              i_cmd,
    input  logic              i_cfg_valid,
    input  logic [RATE_W-1:0] i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_pulse,
    output logic              o_square
);

    localparam int unsigned CW    = COUNTER_WIDTH;
    localparam int unsigned DEN_W = (CW > TDEN_W) ? CW : TDEN_W;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_GO   = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    // Divider operations of a block start.
    localparam logic [1:0] OP_MOD = 2'd0;  // period with old divisions
    localparam logic [1:0] OP_TGT = 2'd1;  // target phase from beat
    localparam logic [1:0] OP_REM = 2'd2;  // target modulo that period
    localparam logic [1:0] OP_PER = 2'd3;  // new period

    logic [1:0]           r_state;
    logic [1:0]           r_op;
    logic [RATE_W-1:0]    r_rate;
    logic [BPM_W-1:0]     r_tempo;
    logic [BEAT_W-1:0]    r_beat;
    logic [DIV_W-1:0]     r_div;
    logic                 r_last_sync;
    logic [CW-1:0]        r_phase;
    logic [CW-1:0]        r_period;
    logic [CW-2:0]        r_half;
    logic                 r_new_sync;
    logic [DIV_W-1:0]     r_new_div;
    logic [PER_NUM_W-1:0] r_num_per;
    logic [PDEN_W-1:0]    r_den_old;
    logic [PDEN_W-1:0]    r_den_new;
    logic [DIV_NUM_W-1:0] r_num_tgt;
    logic [TDEN_W-1:0]    r_den_tgt;
    logic [TGT_W-1:0]     r_tgt_q;
    logic [CW-1:0]        r_modulus;
    logic                 r_out_valid;
    logic                 r_pulse;
    logic                 r_square;

    logic                 w_out_free;
    logic                 w_pop;
    logic                 w_pop_tick;
    logic [21:0]          w_rate15;
    logic [23:0]          w_rate60;
    logic                 w_div_start;
    logic [DIV_NUM_W-1:0] w_div_num;
    logic [DEN_W-1:0]     w_div_den;
    logic [DIV_CNT_W-1:0] w_div_steps;
    logic                 w_div_busy;
    logic                 w_div_done;
    logic [DIV_NUM_W-1:0] w_quot;
    logic [DEN_W-1:0]     w_rem;
    logic [CW-1:0]        w_quot_sat;

    // A tick needs a free output register; other items are always taken when idle.
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_cmd_ready = (r_state == S_IDLE) && ((i_cmd.op != CMD_TICK) || w_out_free);
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_pop_tick  = w_pop && (i_cmd.op == CMD_TICK);

    // rate*15 and rate*60 by shift and subtract.
    assign w_rate15 = {r_rate, 4'b0} - {4'b0, r_rate};
    assign w_rate60 = {r_rate, 6'b0} - {4'b0, r_rate, 2'b0};

    // Divider operand selection.
    always_comb begin
        case (r_op)
            OP_MOD: begin
                w_div_num   = {r_num_per, {(DIV_NUM_W-PER_NUM_W){1'b0}}};
                w_div_den   = DEN_W'(r_den_old);
                w_div_steps = DIV_CNT_W'(PER_NUM_W);
            end
            OP_TGT: begin
                w_div_num   = r_num_tgt;
                w_div_den   = DEN_W'(r_den_tgt);
                w_div_steps = DIV_CNT_W'(DIV_NUM_W);
            end
            OP_REM: begin
                w_div_num   = {r_tgt_q, {(DIV_NUM_W-TGT_W){1'b0}}};
                w_div_den   = DEN_W'(r_modulus);
                w_div_steps = DIV_CNT_W'(TGT_W);
            end
            default: begin
                w_div_num   = {r_num_per, {(DIV_NUM_W-PER_NUM_W){1'b0}}};
                w_div_den   = DEN_W'(r_den_new);
                w_div_steps = DIV_CNT_W'(PER_NUM_W);
            end
        endcase
    end

    assign w_div_start = (r_state == S_GO);

    tscg_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .i_steps (w_div_steps),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot),
        .o_rem   (w_rem)
    );

    // Period quotients saturate at the counter's full scale.
    assign w_quot_sat = (|w_quot[DIV_NUM_W-1:CW]) ? {CW{1'b1}} : w_quot[CW-1:0];

    // Sample rate register; user writes only while block is idle; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (i_cfg_valid) begin
            r_rate <= i_cfg_data;
        end
    end

    // Operand products for a block start.
    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP) begin
            r_num_per <= {w_rate15, 11'b0};
            r_den_old <= PDEN_W'(r_tempo) * PDEN_W'(r_div);
            r_den_new <= PDEN_W'(r_tempo) * PDEN_W'(r_new_div);
            r_num_tgt <= DIV_NUM_W'(w_rate60) * DIV_NUM_W'(r_beat);
            r_den_tgt <= {r_tempo, 8'b0};
        end
    end

    // Main sequencer and clock state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_PER;
            r_tempo     <= TEMPO_RESET;
            r_beat      <= '0;
            r_div       <= DIV_W'(1);
            r_last_sync <= 1'b0;
            r_phase     <= '0;
            r_period    <= '0;
            r_half      <= '0;
            r_new_sync  <= 1'b0;
            r_new_div   <= DIV_W'(1);
            r_tgt_q     <= '0;
            r_modulus   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        case (i_cmd.op)
                            CMD_TICK: begin
                                r_phase <= (r_phase >= r_period) ? CW'(1)
                                                                 : r_phase + CW'(1);
                            end
                            CMD_BLOCK: begin
                                if (!i_cmd.sync) begin
                                    r_tempo <= i_cmd.bpm;
                                end
                                r_new_sync <= i_cmd.sync;
                                r_new_div  <= i_cmd.div;
                                r_state    <= S_PREP;
                            end
                            CMD_HOST: begin
                                if (i_cmd.has_bpm) begin
                                    r_tempo <= i_cmd.bpm;
                                end
                                if (i_cmd.has_beat) begin
                                    r_beat <= i_cmd.beat;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PREP: begin
                    r_op    <= (r_new_sync != r_last_sync) ? OP_MOD : OP_PER;
                    r_state <= S_GO;
                end
                S_GO: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_div_done) begin
                        unique case (r_op)
                            OP_MOD: begin
                                r_modulus <= w_quot_sat;
                                r_op      <= OP_TGT;
                                r_state   <= S_GO;
                            end
                            OP_TGT: begin
                                r_tgt_q <= w_quot[TGT_W-1:0];
                                r_state <= S_GO;
                                // A zero period realigns the phase to zero.
                                if (r_modulus == '0) begin
                                    r_phase     <= '0;
                                    r_last_sync <= r_new_sync;
                                    r_op        <= OP_PER;
                                end else begin
                                    r_op <= OP_REM;
                                end
                            end
                            OP_REM: begin
                                r_phase     <= w_rem[CW-1:0];
                                r_last_sync <= r_new_sync;
                                r_op        <= OP_PER;
                                r_state     <= S_GO;
                            end
                            default: begin
                                r_period <= w_quot_sat;
                                r_half   <= w_quot_sat[CW-1:1];
                                r_div    <= r_new_div;
                                r_state  <= S_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result register for ticks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop_tick) begin
            r_pulse  <= (r_phase >= r_period);
            r_square <= (r_phase >= r_period) || (r_phase < {1'b0, r_half});
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pulse     = r_pulse;
    assign o_square    = r_square;

    // The divider finishes only while the sequencer waits on it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_WAIT))
        else $error("divider finished outside the wait state");

    // The divider is never restarted while it is still running.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider restarted while busy");

    // Half period always tracks the period.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half == r_period[CW-1:1])
        else $error("half period out of step with period");

    // Tempo and divisions never fall below their minimums.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tempo >= TEMPO_MIN) && (r_div != '0))
        else $error("tempo or divisions below minimum");

    // A taken tick always leaves a result waiting.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop_tick |=> r_out_valid)
        else $error("tick taken without a result");

endmodule

// ----- rtl/core/tempo_synced_clock_generator_core.sv -----
// Tempo-synced clock generator: a sample tick gives one pulse and square bit,
// with a period set by a Q.8 tempo and a division count. A block start makes
// one pass of the shared one-bit-per-cycle divider over a 33-bit dividend.
// When the sync setting changes, three more divider passes (33, 46 and 30
// bits) first realign the phase to the host beat, or two (33 and 46 bits)
// when the realigning period is zero. A two-entry queue lets new items arrive
// while a block start runs, and a result register lets the next item be taken
// while a result waits; a tick is taken only once the waiting result is
// accepted.
// Depends on tscg_pkg, tscg_front, tscg_exec and tscg_div.
module tempo_synced_clock_generator_core
    import tscg_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [RATE_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [BPM_W-1:0]  i_control_bpm,
    input  logic [DIV_W-1:0]  i_divisions_in,
    input  logic              i_sync_on,
    input  logic              i_has_host_bpm,
    input  logic [BPM_W-1:0]  i_host_bpm,
    input  logic              i_has_beat,
    input  logic [BEAT_W-1:0] i_host_beat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_pulse,
    output logic              o_square
);

    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_ready;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    tscg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_control_bpm  (i_control_bpm),
        .i_divisions_in (i_divisions_in),
        .i_sync_on      (i_sync_on),
        .i_has_host_bpm (i_has_host_bpm),
        .i_host_bpm     (i_host_bpm),
        .i_has_beat     (i_has_beat),
        .i_host_beat    (i_host_beat),
        .o_cmd_valid    (w_cmd_valid),
        .i_cmd_ready    (w_cmd_ready),
        .o_cmd          (w_cmd)
    );

    tscg_exec #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pulse     (o_pulse),
        .o_square    (o_square)
    );

endmodule

// ----- verif/tb_tempo_synced_clock_generator_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for tempo_synced_clock_generator_core: a directed table
// followed by random phases at several sample rates, checked by a tempo clock model.
// Depends on tscg_pkg and the RTL of the block; reads no files.
module tb_tempo_synced_clock_generator_core;
    import tscg_pkg::*;

    localparam int unsigned CW            = 25;
    localparam logic [CW-1:0] CTR_MAX     = '1;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned SETTLE_CYCLES = 600;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned NUM_PHASES    = 8;
    localparam int unsigned NUM_ROWS      = 19;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BPM_W-1:0]  control_bpm;
        logic [DIV_W-1:0]  divisions_in;
        logic              sync_on;
        logic              has_host_bpm;
        logic [BPM_W-1:0]  host_bpm;
        logic              has_beat;
        logic [BEAT_W-1:0] host_beat;
    } t_item;

    typedef struct packed {
        logic pulse;
        logic square;
    } t_tick_out;

    typedef struct packed {
        t_item     item;
        logic      typed;
        t_tick_out typed_out;
    } t_row;

    localparam t_item TICK = '{KIND_TICK, 17'd0, 5'd0, 1'b0, 1'b0, 17'd0, 1'b0, 22'd0};
    localparam t_tick_out NO_OUT = '{1'b0, 1'b0};
    localparam t_tick_out RESTART = '{1'b1, 1'b1};

    // Directed table: zero period after reset, tempo and division extremes, sync changes.
    localparam t_row DIRECTED [NUM_ROWS] = '{
        '{TICK, 1'b1, RESTART},
        '{TICK, 1'b1, RESTART},
        '{'{KIND_UNUSED, 17'h1FFFF, 5'h1F, 1'b1, 1'b1, 17'h1FFFF, 1'b1, 22'h3FFFFF},
          1'b0, NO_OUT},
        '{'{KIND_HOST, 17'h1FFFF, 5'd0, 1'b1, 1'b1, 17'd0, 1'b1, 22'h3FFFFF}, 1'b0, NO_OUT},
        '{'{KIND_BLOCK, 17'd76800, 5'd16, 1'b0, 1'b0, 17'd0, 1'b0, 22'd0}, 1'b0, NO_OUT},
        '{TICK, 1'b0, NO_OUT},
        '{TICK, 1'b0, NO_OUT},
        '{'{KIND_BLOCK, 17'd0, 5'd0, 1'b1, 1'b1, 17'h1FFFF, 1'b1, 22'd0}, 1'b0, NO_OUT},
        '{TICK, 1'b0, NO_OUT},
        '{TICK, 1'b0, NO_OUT},
        '{'{KIND_HOST, 17'd0, 5'h1F, 1'b1, 1'b0, 17'h1FFFF, 1'b0, 22'd0}, 1'b0, NO_OUT},
        '{'{KIND_HOST, 17'd0, 5'd0, 1'b0, 1'b1, 17'h1FFFF, 1'b1, 22'd0}, 1'b0, NO_OUT},
        '{'{KIND_BLOCK, 17'h1FFFF, 5'h1F, 1'b1, 1'b0, 17'd0, 1'b0, 22'd0}, 1'b0, NO_OUT},
        '{TICK, 1'b0, NO_OUT},
        '{'{KIND_BLOCK, 17'd255, 5'd1, 1'b0, 1'b0, 17'd0, 1'b0, 22'd0}, 1'b0, NO_OUT},
        '{TICK, 1'b0, NO_OUT},
        '{TICK, 1'b0, NO_OUT},
        '{'{KIND_BLOCK, 17'd256, 5'd1, 1'b0, 1'b0, 17'd0, 1'b0, 22'd0}, 1'b0, NO_OUT},
        '{TICK, 1'b0, NO_OUT}
    };

    // Sample rate per random phase, with zero and the full 18-bit value among them.
    localparam logic [RATE_W-1:0] RATE_PLAN [NUM_PHASES] =
        '{18'd0, 18'd262143, 18'd700, 18'd8000, 18'd1, 18'd192000, 18'd300, 18'd1500};
    localparam int unsigned PHASE_ITEMS [NUM_PHASES] = '{60, 60, 200, 100, 60, 60, 200, 160};

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [RATE_W-1:0] i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [KIND_W-1:0] i_kind;
    logic [BPM_W-1:0]  i_control_bpm;
    logic [DIV_W-1:0]  i_divisions_in;
    logic              i_sync_on;
    logic              i_has_host_bpm;
    logic [BPM_W-1:0]  i_host_bpm;
    logic              i_has_beat;
    logic [BEAT_W-1:0] i_host_beat;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_pulse;
    logic              o_square;

    // Clock model state.
    logic [RATE_W-1:0] m_rate;
    logic [BPM_W-1:0]  m_tempo;
    logic [BEAT_W-1:0] m_beat;
    logic [DIV_W-1:0]  m_div;
    logic              m_last_sync;
    logic [CW-1:0]     m_phase;
    logic [CW-1:0]     m_period;
    logic [CW-2:0]     m_half;

    t_tick_out expected_ticks [$];
    int        mismatches = 0;
    logic      calm = 1'b0;
    logic      hold_request = 1'b0;

    tempo_synced_clock_generator_core #(
        .COUNTER_WIDTH(CW)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_control_bpm  (i_control_bpm),
        .i_divisions_in (i_divisions_in),
        .i_sync_on      (i_sync_on),
        .i_has_host_bpm (i_has_host_bpm),
        .i_host_bpm     (i_host_bpm),
        .i_has_beat     (i_has_beat),
        .i_host_beat    (i_host_beat),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pulse        (o_pulse),
        .o_square       (o_square)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Samples per period for a division count at the current rate and tempo.
    function automatic logic [CW-1:0] period_for(input logic [DIV_W-1:0] d);
        logic [63:0] den;
        logic [63:0] q;
        den = 64'(m_tempo) * 64'(d);
        if (den == 64'd0) return CTR_MAX;
        q = (64'(m_rate) * 64'd30720) / den;
        return (q > 64'(CTR_MAX)) ? CTR_MAX : q[CW-1:0];
    endfunction

    // Advance the clock model by one item; ticked is set when the item yields a result.
    task automatic step_clock_model(input t_item it, output logic ticked,
                                    output t_tick_out res);
        logic [CW-1:0] modulus;
        logic [63:0]   target;
        ticked = 1'b0;
        res = NO_OUT;
        case (it.kind)
            KIND_TICK: begin
                ticked = 1'b1;
                if (m_phase >= m_period) begin
                    res = RESTART;
                    m_phase = '0;
                end else begin
                    res.pulse = 1'b0;
                    res.square = (m_phase < {1'b0, m_half});
                end
                m_phase = m_phase + CW'(1);
            end
            KIND_BLOCK: begin
                if (!it.sync_on)
                    m_tempo = (it.control_bpm < TEMPO_MIN) ? TEMPO_MIN : it.control_bpm;
                // A sync change realigns the phase using the old division count.
                if (it.sync_on != m_last_sync) begin
                    modulus = period_for(m_div);
                    target = (64'(m_rate) * 64'd60 * 64'(m_beat)) / (64'(m_tempo) * 64'd256);
                    m_phase = (modulus == '0) ? '0 : CW'(target % 64'(modulus));
                    m_last_sync = it.sync_on;
                end
                m_div = (it.divisions_in == '0) ? DIV_W'(1) : it.divisions_in;
                m_period = period_for(m_div);
                m_half = m_period[CW-1:1];
            end
            KIND_HOST: begin
                if (it.has_host_bpm)
                    m_tempo = (it.host_bpm < TEMPO_MIN) ? TEMPO_MIN : it.host_bpm;
                if (it.has_beat) m_beat = it.host_beat;
            end
            default: ;
        endcase
    endtask

    // Offer one item from a falling edge, with random idling first unless calm; returns at the edge of its transfer.
    task automatic offer_item(input t_item it, input logic typed, input t_tick_out typed_out);
        logic      ticked;
        t_tick_out predicted;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 28) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_kind         = it.kind;
        i_control_bpm  = it.control_bpm;
        i_divisions_in = it.divisions_in;
        i_sync_on      = it.sync_on;
        i_has_host_bpm = it.has_host_bpm;
        i_host_bpm     = it.host_bpm;
        i_has_beat     = it.has_beat;
        i_host_beat    = it.host_beat;
        i_in_valid     = 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        step_clock_model(it, ticked, predicted);
        if (ticked) expected_ticks.push_back(typed ? typed_out : predicted);
    endtask

    // Stop offering and wait for every outstanding result, optionally letting
    // a block start that yields no result finish as well.
    task automatic wait_idle(input logic settle);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_ticks.size() != 0) @(negedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_tick_out exp_out;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_ticks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: pulse=%0b square=%0b",
                             o_pulse, o_square);
            end else begin
                exp_out = expected_ticks.pop_front();
                if (o_pulse !== exp_out.pulse || o_square !== exp_out.square) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tick mismatch: expected pulse=%0b square=%0b, %s%0b %s%0b",
                                 exp_out.pulse, exp_out.square,
                                 "got pulse=", o_pulse, "square=", o_square);
                end
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = calm ? 1'b1 : ($urandom_range(99) >= 28);
            end
        end
    end

    initial begin
        #8_000_000;
        $display("[tempo_synced_clock_generator_core] ERROR");
        $finish;
    end

    // Stimulus.
    initial begin
        t_item it;
        int    pick;
        int    issued;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_kind         = KIND_TICK;
        i_control_bpm  = '0;
        i_divisions_in = '0;
        i_sync_on      = 1'b0;
        i_has_host_bpm = 1'b0;
        i_host_bpm     = '0;
        i_has_beat     = 1'b0;
        i_host_beat    = '0;
        m_rate         = RATE_RESET;
        m_tempo        = TEMPO_RESET;
        m_beat         = '0;
        m_div          = DIV_W'(1);
        m_last_sync    = 1'b0;
        m_phase        = '0;
        m_period       = '0;
        m_half         = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < NUM_ROWS; r++)
            offer_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].typed_out);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle(1'b1);
            // Rate write while the block is idle.
            i_cfg_data  = RATE_PLAN[ph];
            i_cfg_valid = 1'b1;
            forever begin
                @(posedge i_clk);
                if (o_cfg_ready) break;
            end
            m_rate = RATE_PLAN[ph];
            @(negedge i_clk);
            i_cfg_valid = 1'b0;
            // One long phase runs with no idling on either side.
            calm = (ph == 2);
            issued = 0;
            while (issued < PHASE_ITEMS[ph]) begin
                pick = $urandom_range(99);
                it.kind = (pick < 68) ? KIND_TICK :
                          (pick < 80) ? KIND_BLOCK :
                          (pick < 94) ? KIND_HOST : KIND_UNUSED;
                it.control_bpm  = BPM_W'($urandom_range(131071));
                it.divisions_in = DIV_W'($urandom_range(31));
                it.sync_on      = 1'($urandom_range(1));
                it.has_host_bpm = 1'($urandom_range(1));
                it.host_bpm     = BPM_W'($urandom_range(131071));
                it.has_beat     = 1'($urandom_range(1));
                it.host_beat    = BEAT_W'($urandom_range(4194303));
                if (it.kind != KIND_UNUSED) issued++;
                offer_item(it, 1'b0, NO_OUT);
                // Back-pressure: results held off while items keep coming.
                if (ph == 3 && issued == 20) hold_request = 1'b1;
                // Sender pause until everything outstanding has come back.
                if (ph == 4 && issued == 30) wait_idle(1'b0);
            end
        end
        calm = 1'b0;
        wait_idle(1'b1);

        if (mismatches == 0)
            $display("[tempo_synced_clock_generator_core] OK");
        else
            $display("[tempo_synced_clock_generator_core] ERROR");
        $finish;
    end

endmodule
